// ----- rtl/core/slcd_pkg.sv -----
// ----------------------------------------------------------------------------
// slcd_pkg: shared types and codes for the serial line command decoder
// Token format between the byte front end and the line parser, the result
// format and the command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package slcd_pkg;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_NUL   = 8'd0;

  localparam logic [7:0] SPEED_LIMIT_RST = 8'd20;

  // result codes
  localparam logic [3:0] CMD_STATUS      = 4'd0;
  localparam logic [3:0] CMD_FAULT_CLEAR = 4'd1;
  localparam logic [3:0] CMD_SPEED_SET   = 4'd2;
  localparam logic [3:0] CMD_SPEED_RANGE = 4'd3;
  localparam logic [3:0] CMD_MODE_ECO    = 4'd4;
  localparam logic [3:0] CMD_MODE_NORMAL = 4'd5;
  localparam logic [3:0] CMD_MODE_SPORT  = 4'd6;
  localparam logic [3:0] CMD_MODE_BAD    = 4'd7;
  localparam logic [3:0] CMD_UNKNOWN     = 4'd8;

  typedef enum logic [1:0] {
    TOK_CHAR,   // byte appended to the line
    TOK_END,    // newline: decode the line
    TOK_CLEAR   // overflow: line restarts, no result
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    logic [3:0] code;
    logic [7:0] speed;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/slcd_fifo.sv -----
// ----------------------------------------------------------------------------
// slcd_fifo: small register queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slcd_front.sv -----
// ----------------------------------------------------------------------------
// slcd_front: byte classifier and line length tracker
// Drops carriage returns, counts stored bytes, and turns each byte into a
// token for the parser: append, end of line, or overflow restart.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_front
  import slcd_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [7:0] byte_i,
  output logic            tok_wr_o,
  output tok_t            tok_o
);

  localparam int unsigned LW = $clog2(LINE_MAX);

  logic [LW-1:0] len_q, len_d;

  always_comb begin
    len_d      = len_q;
    tok_wr_o   = 1'b0;
    tok_o.kind = TOK_CHAR;
    tok_o.data = byte_i;
    if (acc_i) begin
      priority if (byte_i == CHAR_LF) begin
        len_d      = '0;
        tok_wr_o   = 1'b1;
        tok_o.kind = TOK_END;
      end else if (byte_i == CHAR_CR) begin
        len_d = len_q;
      end else if (len_q < LW'(LINE_MAX - 1)) begin
        len_d    = len_q + LW'(1);
        tok_wr_o = 1'b1;
      end else begin
        // overflow: byte dropped, line restarts
        len_d      = '0;
        tok_wr_o   = 1'b1;
        tok_o.kind = TOK_CLEAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slcd_back.sv -----
// ----------------------------------------------------------------------------
// slcd_back: streaming line parser
// Matches keywords, parses the speed argument one token per cycle (a newline
// waits on a full result queue), emits one result per non-empty line at end.
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_back
  import slcd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] speed_limit_i,
  input  wire logic       tok_empty_i,
  input  wire tok_t       tok_i,
  output logic            tok_rd_o,
  input  wire logic       res_full_i,
  output logic            res_wr_o,
  output res_t            res_o
);

  localparam logic [8*11-1:0] KW_STATUS = 88'("status");
  localparam logic [8*11-1:0] KW_FAULT  = 88'("fault clear");
  localparam logic [8*11-1:0] KW_SPEED  = 88'("set speed");
  localparam logic [8*11-1:0] KW_MODE   = 88'("set mode");
  localparam logic [8*11-1:0] KW_ECO    = 88'("eco");
  localparam logic [8*11-1:0] KW_NORMAL = 88'("normal");
  localparam logic [8*11-1:0] KW_SPORT  = 88'("sport");

  localparam logic [9:0] SPEED_SAT = 10'd999;

  // speed argument parse phase
  localparam logic [1:0] ARG_WS  = 2'd0;
  localparam logic [1:0] ARG_DIG = 2'd1;
  localparam logic [1:0] ARG_END = 2'd2;

  // character idx of a right-aligned keyword of length len
  function automatic logic [7:0] kw_byte(input logic [8*11-1:0] kw,
                                         input logic [3:0] len,
                                         input logic [3:0] idx);
    logic [3:0]      sh;
    logic [8*11-1:0] v;
    sh = len - 4'd1 - idx;
    v  = kw >> {sh, 3'b000};
    return v[7:0];
  endfunction

  logic [3:0] pos_q, pos_d;      // effective length, saturating
  logic       zero_q, zero_d;    // NUL seen: rest of line ignored
  logic       st_q, st_d, fc_q, fc_d, sp_q, sp_d, md_q, md_d;
  logic [1:0] arg_q, arg_d;
  logic       neg_q, neg_d;
  logic [9:0] mag_q, mag_d;
  logic       mskip_q, mskip_d;
  logic [2:0] mpos_q, mpos_d;
  logic       eco_q, eco_d, nrm_q, nrm_d, spt_q, spt_d;
  logic       mres_v_q, mres_v_d;
  logic [3:0] mres_q, mres_d;

  logic [7:0]  c;
  logic [3:0]  dig;
  logic        is_dig, is_ws, clear_line;
  logic [13:0] mag_nx;
  res_t        dec;

  assign c      = tok_i.data;
  assign dig    = c[3:0];
  assign is_dig = (c >= "0") && (c <= "9");
  assign is_ws  = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign mag_nx = 14'(mag_q) * 14'd10 + 14'(dig);

  // line decode from the parse state
  always_comb begin
    dec.code  = CMD_UNKNOWN;
    dec.speed = '0;
    priority if (st_q && pos_q == 4'd6) begin
      dec.code = CMD_STATUS;
    end else if (fc_q && pos_q == 4'd11) begin
      dec.code = CMD_FAULT_CLEAR;
    end else if (sp_q && pos_q >= 4'd9) begin
      if ((neg_q && mag_q != '0) || (mag_q > {2'b00, speed_limit_i})) begin
        dec.code = CMD_SPEED_RANGE;
      end else begin
        dec.code  = CMD_SPEED_SET;
        dec.speed = mag_q[7:0];
      end
    end else if (md_q && pos_q >= 4'd8) begin
      dec.code = mres_v_q ? mres_q : CMD_MODE_BAD;
    end else begin
      dec.code = CMD_UNKNOWN;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    zero_d   = zero_q;
    st_d     = st_q;
    fc_d     = fc_q;
    sp_d     = sp_q;
    md_d     = md_q;
    arg_d    = arg_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    mskip_d  = mskip_q;
    mpos_d   = mpos_q;
    eco_d    = eco_q;
    nrm_d    = nrm_q;
    spt_d    = spt_q;
    mres_v_d = mres_v_q;
    mres_d   = mres_q;
    tok_rd_o   = 1'b0;
    res_wr_o   = 1'b0;
    res_o      = dec;
    clear_line = 1'b0;

    if (!tok_empty_i) begin
      unique case (tok_i.kind)
        TOK_CHAR: begin
          tok_rd_o = 1'b1;
          if (!zero_q && c == CHAR_NUL) begin
            zero_d = 1'b1;
          end else if (!zero_q) begin
            pos_d = (pos_q == 4'hF) ? pos_q : pos_q + 4'd1;
            st_d  = st_q && (pos_q < 4'd6) && (c == kw_byte(KW_STATUS, 4'd6, pos_q));
            fc_d  = fc_q && (pos_q < 4'd11) && (c == kw_byte(KW_FAULT, 4'd11, pos_q));
            if (pos_q < 4'd9) begin
              sp_d = sp_q && (c == kw_byte(KW_SPEED, 4'd9, pos_q));
            end else if (sp_q) begin
              unique case (arg_q)
                ARG_WS: begin
                  priority if (is_ws) begin
                    arg_d = ARG_WS;
                  end else if (c == "+" || c == "-") begin
                    neg_d = (c == "-");
                    arg_d = ARG_DIG;
                  end else if (is_dig) begin
                    mag_d = 10'(dig);
                    arg_d = ARG_DIG;
                  end else begin
                    arg_d = ARG_END;
                  end
                end
                ARG_DIG: begin
                  if (is_dig) begin
                    mag_d = (mag_nx > 14'(SPEED_SAT)) ? SPEED_SAT : mag_nx[9:0];
                  end else begin
                    arg_d = ARG_END;
                  end
                end
                default: begin
                  arg_d = ARG_END;
                end
              endcase
            end
            if (pos_q < 4'd8) begin
              md_d = md_q && (c == kw_byte(KW_MODE, 4'd8, pos_q));
            end else if (md_q && !mres_v_q && !(mskip_q && c == " ")) begin
              mskip_d = 1'b0;
              mpos_d  = (mpos_q == 3'd7) ? mpos_q : mpos_q + 3'd1;
              eco_d   = eco_q && (mpos_q < 3'd3) &&
                        (c == kw_byte(KW_ECO, 4'd3, {1'b0, mpos_q}));
              nrm_d   = nrm_q && (mpos_q < 3'd6) &&
                        (c == kw_byte(KW_NORMAL, 4'd6, {1'b0, mpos_q}));
              spt_d   = spt_q && (mpos_q < 3'd5) &&
                        (c == kw_byte(KW_SPORT, 4'd5, {1'b0, mpos_q}));
              priority if (eco_d && mpos_q == 3'd2) begin
                mres_v_d = 1'b1;
                mres_d   = CMD_MODE_ECO;
              end else if (nrm_d && mpos_q == 3'd5) begin
                mres_v_d = 1'b1;
                mres_d   = CMD_MODE_NORMAL;
              end else if (spt_d && mpos_q == 3'd4) begin
                mres_v_d = 1'b1;
                mres_d   = CMD_MODE_SPORT;
              end else begin
                mres_v_d = 1'b0;
              end
            end
          end
        end
        TOK_END: begin
          if (!res_full_i) begin
            tok_rd_o   = 1'b1;
            res_wr_o   = (pos_q != '0);
            clear_line = 1'b1;
          end
        end
        TOK_CLEAR: begin
          tok_rd_o   = 1'b1;
          clear_line = 1'b1;
        end
        default: begin
          tok_rd_o = 1'b1;
        end
      endcase
    end

    if (clear_line) begin
      pos_d    = '0;
      zero_d   = 1'b0;
      st_d     = 1'b1;
      fc_d     = 1'b1;
      sp_d     = 1'b1;
      md_d     = 1'b1;
      arg_d    = ARG_WS;
      neg_d    = 1'b0;
      mag_d    = '0;
      mskip_d  = 1'b1;
      mpos_d   = '0;
      eco_d    = 1'b1;
      nrm_d    = 1'b1;
      spt_d    = 1'b1;
      mres_v_d = 1'b0;
      mres_d   = CMD_MODE_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      zero_q   <= 1'b0;
      st_q     <= 1'b1;
      fc_q     <= 1'b1;
      sp_q     <= 1'b1;
      md_q     <= 1'b1;
      arg_q    <= ARG_WS;
      neg_q    <= 1'b0;
      mag_q    <= '0;
      mskip_q  <= 1'b1;
      mpos_q   <= '0;
      eco_q    <= 1'b1;
      nrm_q    <= 1'b1;
      spt_q    <= 1'b1;
      mres_v_q <= 1'b0;
      mres_q   <= CMD_MODE_BAD;
    end else begin
      pos_q    <= pos_d;
      zero_q   <= zero_d;
      st_q     <= st_d;
      fc_q     <= fc_d;
      sp_q     <= sp_d;
      md_q     <= md_d;
      arg_q    <= arg_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      mskip_q  <= mskip_d;
      mpos_q   <= mpos_d;
      eco_q    <= eco_d;
      nrm_q    <= nrm_d;
      spt_q    <= spt_d;
      mres_v_q <= mres_v_d;
      mres_q   <= mres_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/serial_line_command_decoder_top.sv -----
// ----------------------------------------------------------------------------
// serial_line_command_decoder_top: text command decoder for a serial line
// Collects received bytes into lines and decodes each finished line into a
// command code and, for a speed command, its value.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  rx byte   | in        | push / full            | rx_byte_i
//  command   | out       | empty / pop            | command_code_o, speed_value_o
//  config    | in        | cfg_valid / cfg_ready  | cfg_data_i (speed limit)
//
//  A byte request is classified in its accepting cycle and written to the
//  token queue; the parser takes one token per cycle while it does not stall,
//  so a byte can be pushed every cycle while full is low.
//  A newline passes through the token queue to the parser, which writes its
//  result into the result queue, where it can be popped.
//  The parser stalls on a newline while the two-entry result queue is full;
//  the two-entry token queue then fills and raises full.
//  Reset clears both queues, the line count and the parser; the speed limit
//  returns to 20. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_command_decoder_top
  import slcd_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // byte input queue side
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  // result queue side
  output logic            empty,
  input  wire logic       pop,
  output logic [3:0]      command_code_o,
  output logic [7:0]      speed_value_o,
  // speed limit register write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data_i
);

  tok_t       tok_in, tok_out;
  res_t       res_in, res_out;
  logic       tok_wr, tok_full, tok_empty, tok_rd;
  logic       res_wr, res_full;
  logic       accept;
  logic [7:0] speed_limit_q;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= SPEED_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      speed_limit_q <= cfg_data_i;
    end
  end

  assign full   = tok_full;
  assign accept = push && !tok_full;

  // front end: CR drop, line length, overflow
  slcd_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (accept),
    .byte_i   (rx_byte_i),
    .tok_wr_o (tok_wr),
    .tok_o    (tok_in)
  );

  // decouples front end from parser
  slcd_fifo #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (2)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tok_wr),
    .wdata_i (tok_in),
    .full_o  (tok_full),
    .rd_i    (tok_rd),
    .rdata_o (tok_out),
    .empty_o (tok_empty)
  );

  // streaming keyword match and argument parse
  slcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .speed_limit_i (speed_limit_q),
    .tok_empty_i   (tok_empty),
    .tok_i         (tok_out),
    .tok_rd_o      (tok_rd),
    .res_full_i    (res_full),
    .res_wr_o      (res_wr),
    .res_o         (res_in)
  );

  // finished results wait here for pop
  slcd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign command_code_o = res_out.code;
  assign speed_value_o  = res_out.speed;

endmodule

`default_nettype wire
